### sv/wspf_pkg.sv
package wspf_pkg;

	localparam int MUL_AW = 34;
	localparam int MUL_BW = 17;
	localparam int MUL_PW = 51;
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = 6;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_KP_BASE     = 3'd0;
	localparam logic [2:0] REG_KP_MAX      = 3'd1;
	localparam logic [2:0] REG_KP_FULL_ERR = 3'd2;
	localparam logic [2:0] REG_KP_SHAPE    = 3'd3;
	localparam logic [2:0] REG_KI_GAIN     = 3'd4;
	localparam logic [2:0] REG_SAMPLE_US   = 3'd5;
	localparam logic [2:0] REG_DUTY_MIN    = 3'd6;
	localparam logic [2:0] REG_DUTY_MAX    = 3'd7;

	// Feedforward fit, Q.16; FF_C is the ramp top K_lo*30 + B_lo
	localparam logic [26:0] FF_C    [2] = '{27'd75422941, 27'd81244640};
	localparam logic [20:0] FF_K_LO [2] = '{21'd1360957, 21'd1449675};
	localparam logic [25:0] FF_B_LO [2] = '{26'd34594231, 26'd37754390};
	localparam logic [20:0] FF_K_HI [2] = '{21'd1611993, 21'd1597350};
	localparam logic [25:0] FF_B_HI [2] = '{26'd12863496, 26'd27770704};

	localparam logic [15:0] FF_LOW_EDGE = 16'd480;
	localparam logic [15:0] FF_MID_EDGE = 16'd1280;
	localparam logic [15:0] INT_ERR_MAX = 16'd320;
	localparam logic signed [16:0] STEP_MIN = 17'sd320;
	localparam logic signed [19:0] INT_LIMIT = 20'sd128000;
	localparam logic signed [15:0] SHAPE_FLOOR = -16'sd15565;
	localparam logic [23:0] INT_DIVISOR = 24'd16000000;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_FF_MUL = 12'b0000_0000_0010,
		ST_FF_DIV = 12'b0000_0000_0100,
		ST_KP_NUM = 12'b0000_0000_1000,
		ST_KP_DEN = 12'b0000_0001_0000,
		ST_KP_DIV = 12'b0000_0010_0000,
		ST_KP_MUL = 12'b0000_0100_0000,
		ST_P_MUL  = 12'b0000_1000_0000,
		ST_I_MUL1 = 12'b0001_0000_0000,
		ST_I_MUL2 = 12'b0010_0000_0000,
		ST_I_DIV  = 12'b0100_0000_0000,
		ST_SUM    = 12'b1000_0000_0000
	} state_t;

endpackage

### sv/wspf_mul.sv
// Shift-add multiplier, one multiplier bit per cycle; stops once the
// remaining multiplier bits are all zero.
module wspf_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wspf_pkg::mul_req_t           req,
	output wspf_pkg::unit_sts_t          sts,
	output logic [wspf_pkg::MUL_PW-1:0]  prod
);

	logic                        busy_q;
	logic [wspf_pkg::MUL_PW-1:0] acc_q;
	logic [wspf_pkg::MUL_PW-1:0] sh_q;
	logic [wspf_pkg::MUL_BW-1:0] b_q;

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (b_q == '0);
	assign prod     = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (sts.done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= wspf_pkg::MUL_PW'(req.a);
			b_q   <= req.b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + sh_q;
			end
			sh_q <= sh_q << 1;
			b_q  <= b_q >> 1;
		end
	end

endmodule

### sv/wspf_div.sv
// Restoring divider, one quotient bit per cycle.
module wspf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wspf_pkg::div_req_t           req,
	output wspf_pkg::unit_sts_t          sts,
	output logic [wspf_pkg::DIV_NW-1:0]  quo
);

	logic                        busy_q;
	logic [wspf_pkg::DIV_CW-1:0] cnt_q;
	logic [wspf_pkg::DIV_NW-1:0] quo_q;
	logic [wspf_pkg::DIV_DW-1:0] rem_q;
	logic [wspf_pkg::DIV_DW-1:0] den_q;
	logic [wspf_pkg::DIV_DW:0]   trial;
	logic                        ge;

	assign trial    = {rem_q, quo_q[wspf_pkg::DIV_NW-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == '0);
	assign quo      = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= wspf_pkg::DIV_CW'(wspf_pkg::DIV_NW);
		end else if (sts.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q && (cnt_q != '0)) begin
			quo_q <= {quo_q[wspf_pkg::DIV_NW-2:0], ge};
			rem_q <= ge ? wspf_pkg::DIV_DW'(trial - {1'b0, den_q})
			            : trial[wspf_pkg::DIV_DW-1:0];
		end
	end

endmodule

### sv/wheel_speed_pid_feedforward_unit.sv
// When the sample period is zero an item goes straight from idle to the final sum;
// otherwise the time per item is set by the bit-serial multiplier (one bit per cycle,
// up to 17 bits per product) and the restoring divider (up to three divisions).
// Throughput: one item at a time; the next item is taken the cycle after the result
// is in the output register, even while that result still waits.
// Reset (arst_n low): configuration registers to their defaults, integral state cleared.
module wheel_speed_pid_feedforward_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               wheel_sel,
	input  logic signed [15:0] target_speed,
	input  logic signed [15:0] measured_speed,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] duty
);

	// Configuration registers
	logic [15:0]        kp_base_q;
	logic [15:0]        kp_max_q;
	logic [14:0]        kp_full_error_q;
	logic signed [15:0] kp_shape_q;
	logic [15:0]        ki_gain_q;
	logic [15:0]        sample_us_q;
	logic signed [15:0] duty_min_q;
	logic signed [15:0] duty_max_q;

	// Per-wheel integral state
	logic signed [17:0] acc_q  [2];
	logic signed [15:0] prev_q [2];
	logic [1:0]         seen_q;

	// Sequencer and item registers
	wspf_pkg::state_t   state_q;
	logic               run_q;
	logic               zero_q;
	logic               w_q;
	logic signed [15:0] t_q;
	logic signed [16:0] e_q;

	// Intermediate results
	logic [33:0]        ffm_q;
	logic [30:0]        num_q;
	logic [30:0]        den_q;
	logic [16:0]        ratio_q;
	logic [31:0]        gain_q;
	logic signed [37:0] p_q;
	logic [24:0]        tmp_q;
	logic [16:0]        iadd_q;

	logic               result_valid_q;
	logic signed [15:0] duty_q;

	wspf_pkg::mul_req_t  mul_req;
	wspf_pkg::div_req_t  div_req;
	wspf_pkg::unit_sts_t mul_sts;
	wspf_pkg::unit_sts_t div_sts;
	logic [wspf_pkg::MUL_PW-1:0] mul_prod;
	logic [wspf_pkg::DIV_NW-1:0] div_quo;

	wspf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	wspf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != wspf_pkg::ST_IDLE);
	assign result_valid = result_valid_q;
	assign duty         = duty_q;

	logic item_xfer;
	logic slot_free;
	assign item_xfer = item_valid && !item_stall;
	assign slot_free = !result_valid_q || !result_stall;

	// Operand preparation: magnitudes of target and error, gain curve inputs
	logic [15:0]        t_u;
	logic [15:0]        ta;
	logic [16:0]        e_u;
	logic [15:0]        ea;
	logic               ff_low;
	logic               ff_mid;
	logic [14:0]        a_g;
	logic signed [15:0] s_c;
	logic signed [17:0] sp1_w;
	logic [15:0]        s_mag;
	logic signed [16:0] kd;
	logic [15:0]        kd_mag;

	always_comb begin
		t_u    = t_q;
		ta     = t_u[15] ? 16'(~t_u + 16'd1) : t_u;
		e_u    = e_q;
		ea     = e_u[16] ? 16'(~e_u + 17'd1) : e_u[15:0];
		ff_low = ta < wspf_pkg::FF_LOW_EDGE;
		ff_mid = ta <= wspf_pkg::FF_MID_EDGE;
		a_g    = (ea > {1'b0, kp_full_error_q}) ? kp_full_error_q : ea[14:0];
		s_c    = (kp_shape_q < wspf_pkg::SHAPE_FLOOR) ? wspf_pkg::SHAPE_FLOOR : kp_shape_q;
		sp1_w  = 18'sd16384 + 18'(s_c);
		s_mag  = s_c[15] ? 16'(-s_c) : 16'(s_c);
		kd     = $signed({1'b0, kp_max_q}) - $signed({1'b0, kp_base_q});
		kd_mag = kd[16] ? 16'(-kd) : kd[15:0];
	end

	// Route operands to the shared serial units by sequencer state
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			wspf_pkg::ST_FF_MUL: begin
				mul_req.start = !run_q;
				mul_req.a = ff_low ? 34'(wspf_pkg::FF_C[w_q])
				          : ff_mid ? 34'(wspf_pkg::FF_K_LO[w_q])
				                   : 34'(wspf_pkg::FF_K_HI[w_q]);
				mul_req.b = 17'(ta);
			end
			wspf_pkg::ST_FF_DIV: begin
				div_req.start = !run_q;
				div_req.num   = mul_prod[wspf_pkg::DIV_NW-1:0];
				div_req.den   = 32'(wspf_pkg::FF_LOW_EDGE);
			end
			wspf_pkg::ST_KP_NUM: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(sp1_w[15:0]);
				mul_req.b     = 17'(a_g);
			end
			wspf_pkg::ST_KP_DEN: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(s_mag);
				mul_req.b     = 17'(a_g);
			end
			wspf_pkg::ST_KP_DIV: begin
				div_req.start = !run_q;
				div_req.num   = 48'({num_q, 16'b0});
				div_req.den   = 32'(den_q);
			end
			wspf_pkg::ST_KP_MUL: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(kd_mag);
				mul_req.b     = ratio_q;
			end
			wspf_pkg::ST_P_MUL: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(gain_q);
				mul_req.b     = 17'(ea);
			end
			wspf_pkg::ST_I_MUL1: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(ki_gain_q);
				mul_req.b     = 17'(ea);
			end
			wspf_pkg::ST_I_MUL2: begin
				mul_req.start = !run_q;
				mul_req.a     = 34'(tmp_q);
				mul_req.b     = 17'(sample_us_q);
			end
			wspf_pkg::ST_I_DIV: begin
				div_req.start = !run_q;
				div_req.num   = mul_prod[wspf_pkg::DIV_NW-1:0];
				div_req.den   = 32'(wspf_pkg::INT_DIVISOR);
			end
			default: begin
			end
		endcase
	end

	// Results of finished operations
	logic signed [33:0] den_w;
	logic signed [34:0] gain_w;
	logic [35:0]        pm;

	always_comb begin
		den_w = $signed({5'b0, kp_full_error_q, 14'b0})
		      + (s_c[15] ? -$signed({3'b0, mul_prod[30:0]})
		                 :  $signed({3'b0, mul_prod[30:0]}));
		gain_w = $signed({3'b0, kp_base_q, 16'b0})
		       + (kd[16] ? -$signed({3'b0, mul_prod[31:0]})
		                 :  $signed({3'b0, mul_prod[31:0]}));
		pm = mul_prod[47:12];
	end

	// Integral update and final sum, evaluated in the last state
	logic               seen;
	logic signed [15:0] prevv;
	logic signed [17:0] i0;
	logic signed [17:0] i0q;
	logic signed [17:0] i1;
	logic signed [16:0] step;
	logic               rev;
	logic               same;
	logic               big;
	logic               opp;
	logic signed [19:0] i2;
	logic signed [19:0] i3;
	logic signed [17:0] acc_new;
	logic signed [39:0] ff_s;
	logic signed [39:0] sum;
	logic signed [39:0] hi_x;
	logic signed [39:0] lo_x;
	logic signed [39:0] sh;
	logic signed [15:0] d;

	always_comb begin
		seen  = seen_q[w_q];
		prevv = seen ? prev_q[w_q] : t_q;
		i0    = seen ? acc_q[w_q] : 18'sd0;
		rev   = (prevv > 0 && t_q < 0) || (prevv < 0 && t_q > 0);
		same  = (prevv > 0 && t_q > 0) || (prevv < 0 && t_q < 0);
		step  = 17'(t_q) - 17'(prevv);
		big   = (step >= wspf_pkg::STEP_MIN) || (step <= -wspf_pkg::STEP_MIN);
		opp   = (i0 > 0 && e_q < 0) || (i0 < 0 && e_q > 0);
		// quarter, rounding toward zero
		i0q   = (i0 + (i0[17] ? 18'sd3 : 18'sd0)) >>> 2;
		if (prevv == 0 || rev) begin
			i1 = 18'sd0;
		end else if (same && big && opp) begin
			i1 = i0q;
		end else begin
			i1 = i0;
		end
		i2 = 20'(i1) + (e_q[16] ? -$signed({3'b0, iadd_q}) : $signed({3'b0, iadd_q}));
		if (i2 > wspf_pkg::INT_LIMIT) begin
			i3 = wspf_pkg::INT_LIMIT;
		end else if (i2 < -wspf_pkg::INT_LIMIT) begin
			i3 = -wspf_pkg::INT_LIMIT;
		end else begin
			i3 = i2;
		end
		acc_new = (t_q == 0) ? 18'sd0 : i3[17:0];

		ff_s = t_q[15] ? -$signed({6'b0, ffm_q}) : $signed({6'b0, ffm_q});
		sum  = ff_s + 40'(p_q) + (40'(acc_new) <<< 8);
		hi_x = 40'(duty_max_q) <<< 16;
		lo_x = 40'(duty_min_q) <<< 16;
		sh   = (sum >>> 16) + ((sum[39] && sum[15:0] != 16'd0) ? 40'sd1 : 40'sd0);
		if (sum > hi_x) begin
			d = duty_max_q;
		end else if (sum < lo_x) begin
			d = duty_min_q;
		end else begin
			d = sh[15:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_base_q       <= 16'd31;
			kp_max_q        <= 16'd1024;
			kp_full_error_q <= 15'd800;
			kp_shape_q      <= 16'sd0;
			ki_gain_q       <= 16'd1536;
			sample_us_q     <= 16'd10000;
			duty_min_q      <= -16'sd10000;
			duty_max_q      <= 16'sd10000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wspf_pkg::REG_KP_BASE:     kp_base_q       <= cfg_data;
				wspf_pkg::REG_KP_MAX:      kp_max_q        <= cfg_data;
				wspf_pkg::REG_KP_FULL_ERR: kp_full_error_q <= cfg_data[14:0];
				wspf_pkg::REG_KP_SHAPE:    kp_shape_q      <= cfg_data;
				wspf_pkg::REG_KI_GAIN:     ki_gain_q       <= cfg_data;
				wspf_pkg::REG_SAMPLE_US:   sample_us_q     <= cfg_data;
				wspf_pkg::REG_DUTY_MIN:    duty_min_q      <= cfg_data;
				wspf_pkg::REG_DUTY_MAX:    duty_max_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, integral state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= wspf_pkg::ST_IDLE;
			run_q          <= 1'b0;
			zero_q         <= 1'b0;
			result_valid_q <= 1'b0;
			acc_q[0]       <= '0;
			acc_q[1]       <= '0;
			prev_q[0]      <= '0;
			prev_q[1]      <= '0;
			seen_q         <= '0;
		end else begin
			// load a new result, or drop the result once it transfers
			if (state_q == wspf_pkg::ST_SUM && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (mul_req.start || div_req.start) begin
				run_q <= 1'b1;
			end
			case (state_q)
				wspf_pkg::ST_IDLE: begin
					if (item_xfer) begin
						zero_q  <= (sample_us_q == 16'd0);
						state_q <= (sample_us_q == 16'd0) ? wspf_pkg::ST_SUM
						                                  : wspf_pkg::ST_FF_MUL;
					end
				end
				wspf_pkg::ST_FF_MUL: begin
					if (mul_sts.done) begin
						run_q <= 1'b0;
						if (ff_low) begin
							state_q <= wspf_pkg::ST_FF_DIV;
						end else begin
							state_q <= (kp_full_error_q == '0) ? wspf_pkg::ST_P_MUL
							                                   : wspf_pkg::ST_KP_NUM;
						end
					end
				end
				wspf_pkg::ST_FF_DIV: begin
					if (div_sts.done) begin
						run_q   <= 1'b0;
						state_q <= (kp_full_error_q == '0) ? wspf_pkg::ST_P_MUL
						                                   : wspf_pkg::ST_KP_NUM;
					end
				end
				wspf_pkg::ST_KP_NUM: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_KP_DEN;
					end
				end
				wspf_pkg::ST_KP_DEN: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_KP_DIV;
					end
				end
				wspf_pkg::ST_KP_DIV: begin
					if (div_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_KP_MUL;
					end
				end
				wspf_pkg::ST_KP_MUL: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_P_MUL;
					end
				end
				wspf_pkg::ST_P_MUL: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= (ea <= wspf_pkg::INT_ERR_MAX) ? wspf_pkg::ST_I_MUL1
						                                         : wspf_pkg::ST_SUM;
					end
				end
				wspf_pkg::ST_I_MUL1: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_I_MUL2;
					end
				end
				wspf_pkg::ST_I_MUL2: begin
					if (mul_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_I_DIV;
					end
				end
				wspf_pkg::ST_I_DIV: begin
					if (div_sts.done) begin
						run_q   <= 1'b0;
						state_q <= wspf_pkg::ST_SUM;
					end
				end
				wspf_pkg::ST_SUM: begin
					// hold until the output register is free
					if (slot_free) begin
						state_q <= wspf_pkg::ST_IDLE;
						if (!zero_q) begin
							acc_q[w_q]  <= acc_new;
							prev_q[w_q] <= t_q;
							seen_q[w_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= wspf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			w_q    <= wheel_sel;
			t_q    <= target_speed;
			e_q    <= 17'(target_speed) - 17'(measured_speed);
			iadd_q <= '0;
		end
		if (state_q == wspf_pkg::ST_SUM && slot_free) begin
			duty_q <= zero_q ? 16'sd0 : d;
		end
		case (state_q)
			wspf_pkg::ST_FF_MUL: begin
				if (mul_sts.done) begin
					ffm_q <= ff_mid ? 34'(mul_prod[35:4]) + 34'(wspf_pkg::FF_B_LO[w_q])
					                : 34'(mul_prod[35:4]) + 34'(wspf_pkg::FF_B_HI[w_q]);
					if (kp_full_error_q == '0) begin
						gain_q <= {kp_max_q, 16'b0};
					end
				end
			end
			wspf_pkg::ST_FF_DIV: begin
				if (div_sts.done) begin
					ffm_q <= 34'(div_quo[26:0]);
					if (kp_full_error_q == '0) begin
						gain_q <= {kp_max_q, 16'b0};
					end
				end
			end
			wspf_pkg::ST_KP_NUM: begin
				if (mul_sts.done) begin
					num_q <= mul_prod[30:0];
				end
			end
			wspf_pkg::ST_KP_DEN: begin
				if (mul_sts.done) begin
					den_q <= den_w[30:0];
				end
			end
			wspf_pkg::ST_KP_DIV: begin
				if (div_sts.done) begin
					ratio_q <= div_quo[16:0];
				end
			end
			wspf_pkg::ST_KP_MUL: begin
				if (mul_sts.done) begin
					gain_q <= gain_w[31:0];
				end
			end
			wspf_pkg::ST_P_MUL: begin
				if (mul_sts.done) begin
					p_q <= e_q[16] ? -$signed({2'b0, pm}) : $signed({2'b0, pm});
				end
			end
			wspf_pkg::ST_I_MUL1: begin
				if (mul_sts.done) begin
					tmp_q <= mul_prod[24:0];
				end
			end
			wspf_pkg::ST_I_DIV: begin
				if (div_sts.done) begin
					iadd_q <= div_quo[16:0];
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_stall_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> item_stall)
		else $error("item taken while a previous one still in work");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wspf_pkg::ST_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
		else $error("serial unit busy while sequencer idle");

	a_int_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q[0] <= 18'sd128000) && (acc_q[0] >= -18'sd128000) &&
		(acc_q[1] <= 18'sd128000) && (acc_q[1] >= -18'sd128000))
		else $error("integral out of saturation range");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy together");
`endif

endmodule
